// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// shared element types and branch codes for the rotation matrix converter
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ELEM_W = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [1:0]               branch_t;

  localparam branch_t BR_TRACE = 2'd0;
  localparam branch_t BR_X     = 2'd1;
  localparam branch_t BR_Y     = 2'd2;
  localparam branch_t BR_Z     = 2'd3;

endpackage

// ----- rtl/rmq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// valid/ready channels for matrix requests and quaternion results
// ----------------------------------------------------------------------------
interface rmq_in_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;
  logic    valid;
  logic    ready;
  elem_t   quat_x, quat_y, quat_z, quat_w;
  branch_t branch_taken;
  logic    invalid;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, invalid,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, invalid,
                  output ready);
endinterface

// ----- rtl/rmq_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined digit-by-digit integer square root, two root bits per stage
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int NST = 8
) (
  input  logic               clk_i,
  input  logic [NST-1:0]     en_i,
  input  logic [4*NST-1:0]   x_i,
  output logic [2*NST-1:0]   root_o
);
  localparam int X_W   = 4 * NST;
  localparam int R_W   = 2 * NST;
  localparam int REM_W = R_W + 2;

  logic [X_W-1:0]   x_q   [NST];
  logic [R_W-1:0]   r_q   [NST];
  logic [REM_W-1:0] m_q   [NST];
  logic [X_W-1:0]   x_d   [NST];
  logic [R_W-1:0]   r_d   [NST];
  logic [REM_W-1:0] m_d   [NST];
  logic [X_W-1:0]   x_in  [NST];
  logic [R_W-1:0]   r_in  [NST];
  logic [REM_W-1:0] m_in  [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign x_in[g] = x_i;
      assign r_in[g] = '0;
      assign m_in[g] = '0;
    end else begin : g_next
      assign x_in[g] = x_q[g-1];
      assign r_in[g] = r_q[g-1];
      assign m_in[g] = m_q[g-1];
    end

    always_comb begin
      logic [X_W-1:0]   x;
      logic [R_W-1:0]   r;
      logic [REM_W-1:0] m;
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] tr;
      x = x_in[g];
      r = r_in[g];
      m = m_in[g];
      for (int j = 0; j < 2; j++) begin
        t  = {m, x[X_W-1 -: 2]};
        tr = (REM_W+2)'({r, 2'b01});
        if (t >= tr) begin
          m = REM_W'(t - tr);
          r = {r[R_W-2:0], 1'b1};
        end else begin
          m = t[REM_W-1:0];
          r = {r[R_W-2:0], 1'b0};
        end
        x = {x[X_W-3:0], 2'b00};
      end
      x_d[g] = x;
      r_d[g] = r;
      m_d[g] = m;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        x_q[g] <= x_d[g];
        r_q[g] <= r_d[g];
        m_q[g] <= m_d[g];
      end
    end
  end

  assign root_o = r_q[NST-1];

endmodule

// ----- rtl/rmq_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// pipelined restoring divider, three lanes sharing one divisor
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int NST = 8,
  parameter int D_W = 18
) (
  input  logic             clk_i,
  input  logic [NST-1:0]   en_i,
  input  logic [4*NST-1:0] num_i [3],
  input  logic [D_W-1:0]   den_i,
  output logic [4*NST-1:0] quo_o [3]
);
  localparam int N_W = 4 * NST;

  logic [N_W-1:0] n_q  [NST][3];
  logic [D_W-1:0] m_q  [NST][3];
  logic [D_W-1:0] d_q  [NST];
  logic [N_W-1:0] n_d  [NST][3];
  logic [D_W-1:0] m_d  [NST][3];
  logic [N_W-1:0] n_in [NST][3];
  logic [D_W-1:0] m_in [NST][3];
  logic [D_W-1:0] d_in [NST];

  for (genvar g = 0; g < NST; g++) begin : g_stage
    if (g == 0) begin : g_first
      assign d_in[g] = den_i;
    end else begin : g_next
      assign d_in[g] = d_q[g-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      if (g == 0) begin : g_first
        assign n_in[g][l] = num_i[l];
        assign m_in[g][l] = '0;
      end else begin : g_next
        assign n_in[g][l] = n_q[g-1][l];
        assign m_in[g][l] = m_q[g-1][l];
      end

      always_comb begin
        logic [N_W-1:0] n;
        logic [D_W-1:0] m;
        logic [D_W:0]   t;
        n = n_in[g][l];
        m = m_in[g][l];
        for (int j = 0; j < 4; j++) begin
          t = {m, n[N_W-1]};
          if (t >= {1'b0, d_in[g]}) begin
            m = D_W'(t - {1'b0, d_in[g]});
            n = {n[N_W-2:0], 1'b1};
          end else begin
            m = t[D_W-1:0];
            n = {n[N_W-2:0], 1'b0};
          end
        end
        n_d[g][l] = n;
        m_d[g][l] = m;
      end

      always_ff @(posedge clk_i) begin
        if (en_i[g]) begin
          n_q[g][l] <= n_d[g][l];
          m_q[g][l] <= m_d[g][l];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[g]) begin
        d_q[g] <= d_in[g];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = n_q[NST-1][l];
  end

endmodule

// ----- rtl/rotation_matrix_to_quaternion_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// fixed-point rotation matrix to quaternion converter, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one 3x3 matrix request (r00..r22, signed, FRAC_BITS fraction);
//   out_o returns quat_x/y/z/w, branch_taken and invalid for each request, in
//   order. both channels are valid/ready; a transfer happens when both are high.
// path: from acceptance to out_o.valid a request passes the front stage, NSQ
//   square-root stages, the prep stage, NDV divider stages and the output register,
//   where NSQ = ceil((FRAC_BITS + max(FRAC_BITS,17) + 2) / 4) (two root bits each)
//   and NDV = ceil((FRAC_BITS + 19) / 4) (four quotient bits each).
// throughput: one request per cycle while in_i.ready is high; the divider and
//   square-root stages are the depth of each register-to-register path.
// reset: rst_ni clears every stage valid bit; the pipeline comes up empty.
// stall: when out_o.ready is low the result holds, and each stage still moves
//   up into an empty stage ahead of it, so in_i.ready stays high until every
//   stage holds a request.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);
  import rmq_pkg::*;

  // radicand width (signed), square root and divider sizing
  localparam int RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int NSQ  = (RW - 1 + FRAC_BITS + 3) / 4;
  localparam int X_W  = 4 * NSQ;
  localparam int R_W  = 2 * NSQ;
  localparam int D_W  = R_W + 2;
  localparam int NDV  = (FRAC_BITS + 19 + 3) / 4;
  localparam int N_W  = 4 * NDV;
  localparam int NUM_W = 18;
  localparam int T    = NSQ + NDV + 3;
  // stage positions in the valid chain
  localparam int I_SQ = 1;
  localparam int I_P  = 1 + NSQ;
  localparam int I_DV = 2 + NSQ;
  localparam int I_O  = T - 1;

  typedef struct packed {
    branch_t                        br;
    logic                           bad;
    logic signed [2:0][NUM_W-1:0]   num;
  } side_t;

  typedef struct packed {
    branch_t    br;
    logic       bad;
    logic [2:0] neg;
    logic [R_W-1:0] diag;
  } dside_t;

  // valid chain and per-stage advance
  logic [T-1:0] v_q;
  logic [T:0]   en;

  assign en[T] = out_o.ready;
  for (genvar i = 0; i < T; i++) begin : g_en
    assign en[i] = !v_q[i] || en[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < T; i++) begin
        if (en[i]) begin
          v_q[i] <= (i == 0) ? in_i.valid : v_q[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // ---------------- front stage: trace, branch, radicand, numerators -------
  logic signed [NUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr;
  logic signed [RW-1:0]    one, rad_d;
  branch_t                 br_d;
  side_t                   f_side_d, f_side_q;
  logic [RW-2:0]           f_rad_q;

  assign e00 = NUM_W'(in_i.r00);
  assign e01 = NUM_W'(in_i.r01);
  assign e02 = NUM_W'(in_i.r02);
  assign e10 = NUM_W'(in_i.r10);
  assign e11 = NUM_W'(in_i.r11);
  assign e12 = NUM_W'(in_i.r12);
  assign e20 = NUM_W'(in_i.r20);
  assign e21 = NUM_W'(in_i.r21);
  assign e22 = NUM_W'(in_i.r22);
  assign tr  = e00 + e11 + e22;
  assign one = RW'(1) << FRAC_BITS;

  always_comb begin
    // ties on the diagonal fall through to the later branch
    if (tr > 0) begin
      br_d = BR_TRACE;
    end else if (e00 > e11 && e00 > e22) begin
      br_d = BR_X;
    end else if (e11 > e22) begin
      br_d = BR_Y;
    end else begin
      br_d = BR_Z;
    end

    unique case (br_d)
      BR_TRACE: begin
        rad_d = one + RW'(tr);
        f_side_d.num = {e10 - e01, e02 - e20, e21 - e12};
      end
      BR_X: begin
        rad_d = one + RW'(e00) - RW'(e11) - RW'(e22);
        f_side_d.num = {e21 - e12, e02 + e20, e01 + e10};
      end
      BR_Y: begin
        rad_d = one + RW'(e11) - RW'(e00) - RW'(e22);
        f_side_d.num = {e02 - e20, e12 + e21, e01 + e10};
      end
      default: begin
        rad_d = one + RW'(e22) - RW'(e00) - RW'(e11);
        f_side_d.num = {e10 - e01, e12 + e21, e02 + e20};
      end
    endcase
    f_side_d.br  = br_d;
    f_side_d.bad = rad_d[RW-1] || (rad_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      f_side_q <= f_side_d;
      f_rad_q  <= rad_d[RW-2:0];
    end
  end

  // ---------------- square root of rad << FRAC_BITS ------------------------
  logic [X_W-1:0] sq_x;
  logic [R_W-1:0] root;
  side_t          sq_side_q [NSQ];

  assign sq_x = f_side_q.bad ? '0 : X_W'({f_rad_q, {FRAC_BITS{1'b0}}});

  rmq_sqrt #(.NST(NSQ)) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en[I_SQ +: NSQ]),
    .x_i    (sq_x),
    .root_o (root)
  );

  for (genvar k = 0; k < NSQ; k++) begin : g_sq_side
    always_ff @(posedge clk_i) begin
      if (en[I_SQ+k]) begin
        sq_side_q[k] <= (k == 0) ? f_side_q : sq_side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- prep: dividends, divisor 4*root, diagonal term ---------
  side_t          sq_last;
  dside_t         p_side_d, p_side_q;
  logic [N_W-1:0] p_num_d [3];
  logic [N_W-1:0] p_num_q [3];
  logic [D_W-1:0] p_den_q;

  assign sq_last = sq_side_q[NSQ-1];

  always_comb begin
    logic [NUM_W-1:0] neg_num;
    logic [NUM_W-2:0] mag;
    for (int l = 0; l < 3; l++) begin
      neg_num = -sq_last.num[l];
      mag     = sq_last.num[l][NUM_W-1] ? neg_num[NUM_W-2:0]
                                        : sq_last.num[l][NUM_W-2:0];
      // numerator scaled by 2^(FRAC_BITS+1) plus S for round-half-away
      p_num_d[l] = (N_W'(mag) << (FRAC_BITS + 1)) + N_W'({root, 1'b0});
      p_side_d.neg[l] = sq_last.num[l][NUM_W-1];
    end
    p_side_d.br   = sq_last.br;
    p_side_d.bad  = sq_last.bad;
    p_side_d.diag = R_W'((R_W+1)'(root) + (R_W+1)'(1) >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en[I_P]) begin
      p_side_q <= p_side_d;
      p_num_q  <= p_num_d;
      p_den_q  <= {root, 2'b00};
    end
  end

  // ---------------- three-lane divider -------------------------------------
  logic [N_W-1:0] quo [3];
  dside_t         dv_side_q [NDV];

  rmq_div #(.NST(NDV), .D_W(D_W)) u_div (
    .clk_i (clk_i),
    .en_i  (en[I_DV +: NDV]),
    .num_i (p_num_q),
    .den_i (p_den_q),
    .quo_o (quo)
  );

  for (genvar k = 0; k < NDV; k++) begin : g_dv_side
    always_ff @(posedge clk_i) begin
      if (en[I_DV+k]) begin
        dv_side_q[k] <= (k == 0) ? p_side_q : dv_side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- sign, saturate, place, output register -----------------
  dside_t dv_last;
  elem_t  lane [3];
  elem_t  diag_s;
  elem_t  qx_d, qy_d, qz_d, qw_d;
  elem_t  qx_q, qy_q, qz_q, qw_q;
  branch_t br_q;
  logic   bad_q;

  assign dv_last = dv_side_q[NDV-1];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_last.neg[l]) begin
        lane[l] = (quo[l] >= N_W'(32768)) ? elem_t'(-32768) : -elem_t'(quo[l][15:0]);
      end else begin
        lane[l] = (quo[l] > N_W'(32767)) ? elem_t'(32767) : elem_t'(quo[l][15:0]);
      end
    end
    diag_s = ((R_W+1)'(dv_last.diag) > (R_W+1)'(32767)) ? elem_t'(32767)
                                                        : elem_t'(dv_last.diag[15:0]);
    unique case (dv_last.br)
      BR_TRACE: {qx_d, qy_d, qz_d, qw_d} = {lane[0], lane[1], lane[2], diag_s};
      BR_X:     {qx_d, qy_d, qz_d, qw_d} = {diag_s, lane[0], lane[1], lane[2]};
      BR_Y:     {qx_d, qy_d, qz_d, qw_d} = {lane[0], diag_s, lane[1], lane[2]};
      default:  {qx_d, qy_d, qz_d, qw_d} = {lane[0], lane[1], diag_s, lane[2]};
    endcase
    if (dv_last.bad) begin
      {qx_d, qy_d, qz_d, qw_d} = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[I_O]) begin
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      qz_q  <= qz_d;
      qw_q  <= qw_d;
      br_q  <= dv_last.br;
      bad_q <= dv_last.bad;
    end
  end

  assign out_o.valid        = v_q[I_O];
  assign out_o.quat_x       = qx_q;
  assign out_o.quat_y       = qy_q;
  assign out_o.quat_z       = qz_q;
  assign out_o.quat_w       = qw_q;
  assign out_o.branch_taken = br_q;
  assign out_o.invalid      = bad_q;

`ifndef ASSERT_OFF
  // a bad radicand must never leak a nonzero component
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.invalid |->
      out_o.quat_x == '0 && out_o.quat_y == '0 && out_o.quat_z == '0 &&
      out_o.quat_w == '0)
    else $error("invalid result with nonzero quaternion");

  // input backpressure only when every stage is occupied
  a_full_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &v_q)
    else $error("input stalled with an empty stage");

  // trace branch takes w from the root, which is never negative
  a_trace_w : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.invalid && out_o.branch_taken == BR_TRACE |->
      !out_o.quat_w[15])
    else $error("negative w on trace branch");
`endif

endmodule

// ----- verif/tb_rotation_matrix_to_quaternion_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_core
// self-checking bench for the matrix to quaternion converter: directed and
// random matrix requests, random idling on both channels, results predicted
// in the bench and compared field by field in order
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_core;
  import rmq_pkg::*;

  localparam int FRAC_BITS = 14;
  localparam int LATENCY   = 20;
  localparam int N_RANDOM  = 1500;
  localparam int WDOG_MAX  = 2000;
  localparam longint ONE   = 64'sd1 << FRAC_BITS;

  typedef struct {
    elem_t m [3][3];
  } matrix_t;

  typedef struct {
    elem_t   q [4];
    branch_t br;
    logic    bad;
  } quat_res_t;

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   -= res + bit_w;
        res  = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic elem_t clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return elem_t'(v);
  endfunction

  // num * 2^FRAC_BITS / s, nearest with ties away from zero
  function automatic longint scaled_div(longint num, longint unsigned s);
    longint unsigned mag, quo;
    mag = (num < 0) ? longint'(-num) : num;
    quo = ((mag << FRAC_BITS) * 2 + s) / (2 * s);
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic quat_res_t matrix_to_quat(matrix_t mx);
    quat_res_t       r;
    longint          a [3][3];
    longint          tr, rad, diag;
    longint          c [4];
    longint unsigned root, s;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = longint'(mx.m[i][j]);
    tr = a[0][0] + a[1][1] + a[2][2];
    if (tr > 0) begin
      r.br = BR_TRACE; rad = ONE + tr;
    end else if (a[0][0] > a[1][1] && a[0][0] > a[2][2]) begin
      r.br = BR_X; rad = ONE + a[0][0] - a[1][1] - a[2][2];
    end else if (a[1][1] > a[2][2]) begin
      r.br = BR_Y; rad = ONE + a[1][1] - a[0][0] - a[2][2];
    end else begin
      r.br = BR_Z; rad = ONE + a[2][2] - a[0][0] - a[1][1];
    end
    c = '{0, 0, 0, 0};
    r.bad = (rad <= 0);
    if (!r.bad) begin
      root = int_sqrt(longint'(rad) << FRAC_BITS);
      s    = 2 * root;
      diag = (root + 1) >> 1;
      case (r.br)
        BR_TRACE: begin
          c[0] = scaled_div(a[2][1] - a[1][2], s);
          c[1] = scaled_div(a[0][2] - a[2][0], s);
          c[2] = scaled_div(a[1][0] - a[0][1], s);
          c[3] = diag;
        end
        BR_X: begin
          c[0] = diag;
          c[1] = scaled_div(a[0][1] + a[1][0], s);
          c[2] = scaled_div(a[0][2] + a[2][0], s);
          c[3] = scaled_div(a[2][1] - a[1][2], s);
        end
        BR_Y: begin
          c[0] = scaled_div(a[0][1] + a[1][0], s);
          c[1] = diag;
          c[2] = scaled_div(a[1][2] + a[2][1], s);
          c[3] = scaled_div(a[0][2] - a[2][0], s);
        end
        default: begin
          c[0] = scaled_div(a[0][2] + a[2][0], s);
          c[1] = scaled_div(a[1][2] + a[2][1], s);
          c[2] = diag;
          c[3] = scaled_div(a[1][0] - a[0][1], s);
        end
      endcase
    end
    for (int k = 0; k < 4; k++) r.q[k] = clamp16(c[k]);
    return r;
  endfunction

  // in-order store of predicted quaternions
  class quat_scoreboard;
    quat_res_t pending [$];
    int        n_err;

    function void note_matrix(matrix_t mx);
      pending.push_back(matrix_to_quat(mx));
    endfunction

    function void check_quat(quat_res_t got);
      quat_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d", $realtime,
                 got.q[0], got.q[1], got.q[2], got.q[3]);
        n_err++;
        return;
      end
      exp_r = pending.pop_front();
      for (int k = 0; k < 4; k++)
        if (got.q[k] !== exp_r.q[k]) begin
          $display("%0t: component %0d expected %0d actual %0d", $realtime, k,
                   exp_r.q[k], got.q[k]);
          n_err++;
        end
      if (got.br !== exp_r.br) begin
        $display("%0t: branch_taken expected %0d actual %0d", $realtime, exp_r.br, got.br);
        n_err++;
      end
      if (got.bad !== exp_r.bad) begin
        $display("%0t: invalid expected %0b actual %0b", $realtime, exp_r.bad, got.bad);
        n_err++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_core #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  quat_scoreboard sb = new();
  bit             calm;        // no idling in the final stretch
  bit             send_done;
  int             idle_cnt = 0;

  // matrix_t can't go through an interface port list directly, so drive fields
  task automatic put_matrix(matrix_t mx);
    {in_ch.r00, in_ch.r01, in_ch.r02} = {mx.m[0][0], mx.m[0][1], mx.m[0][2]};
    {in_ch.r10, in_ch.r11, in_ch.r12} = {mx.m[1][0], mx.m[1][1], mx.m[1][2]};
    {in_ch.r20, in_ch.r21, in_ch.r22} = {mx.m[2][0], mx.m[2][1], mx.m[2][2]};
  endtask

  // one matrix request: optional idle burst, then hold valid until accepted
  task automatic send_matrix(matrix_t mx);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    put_matrix(mx);
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_matrix(mx);
    @(negedge clk_i);
  endtask

  function automatic elem_t rnd_elem(int lo, int hi);
    return elem_t'($urandom_range(hi - lo) + lo);
  endfunction

  function automatic matrix_t diag_matrix(int d0, int d1, int d2);
    matrix_t mx;
    foreach (mx.m[i, j]) mx.m[i][j] = rnd_elem(-16384, 16384);
    mx.m[0][0] = elem_t'(d0); mx.m[1][1] = elem_t'(d1); mx.m[2][2] = elem_t'(d2);
    return mx;
  endfunction

  // proper rotation from a random unit quaternion
  function automatic matrix_t rot_matrix();
    matrix_t mx;
    real     x, y, z, w, n;
    real     r [3][3];
    x = $urandom_range(0, 2000) - 1000.0; y = $urandom_range(0, 2000) - 1000.0;
    z = $urandom_range(0, 2000) - 1000.0; w = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(x*x + y*y + z*z + w*w) + 1e-9;
    x /= n; y /= n; z /= n; w /= n;
    r[0][0] = 1 - 2*(y*y + z*z); r[0][1] = 2*(x*y - z*w); r[0][2] = 2*(x*z + y*w);
    r[1][0] = 2*(x*y + z*w); r[1][1] = 1 - 2*(x*x + z*z); r[1][2] = 2*(y*z - x*w);
    r[2][0] = 2*(x*z - y*w); r[2][1] = 2*(y*z + x*w); r[2][2] = 1 - 2*(x*x + y*y);
    foreach (r[i, j]) mx.m[i][j] = elem_t'($rtoi(r[i][j] * 16384.0));
    return mx;
  endfunction

  function automatic matrix_t noise_matrix();
    matrix_t mx;
    foreach (mx.m[i, j]) mx.m[i][j] = elem_t'($urandom_range(0, 16'hffff));
    return mx;
  endfunction

  // stimulus
  initial begin
    matrix_t mx;
    in_ch.valid = 1'b0;
    put_matrix(diag_matrix(0, 0, 0));
    calm      = 1'b0;
    send_done = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: identity, extremes, each branch, ties
    send_matrix(diag_matrix(16384, 16384, 16384));
    mx = diag_matrix(16384, 16384, 16384);
    foreach (mx.m[i, j]) if (i != j) mx.m[i][j] = elem_t'(0);
    send_matrix(mx);
    send_matrix(diag_matrix(16384, -16384, -16384));     // x largest
    send_matrix(diag_matrix(-16384, 16384, -16384));     // y largest
    send_matrix(diag_matrix(-16384, -16384, 16384));     // z largest
    send_matrix(diag_matrix(-16384, 0, 0));              // r11/r22 tie
    send_matrix(diag_matrix(0, 0, 0));                   // all tie, trace zero
    send_matrix(diag_matrix(-100, -100, -200));          // r00/r11 tie
    send_matrix(diag_matrix(-16384, -16384, -16384));    // all tie, trace negative
    send_matrix(diag_matrix(-8192, -8192, -16384));      // r00/r11 tie, trace negative
    send_matrix(diag_matrix(1, 0, 0));                   // smallest positive trace
    mx = diag_matrix(-16384, -16384, -16384);
    foreach (mx.m[i, j]) mx.m[i][j] = elem_t'(-16384);
    mx.m[0][0] = elem_t'(0);
    send_matrix(mx);
    mx = diag_matrix(16384, 16384, 16384);
    foreach (mx.m[i, j]) mx.m[i][j] = (i < j) ? elem_t'(-16384) : elem_t'(16384);
    send_matrix(mx);
    mx.m = '{'{16'sh7fff, 16'sh8000, 16'sh7fff}, '{16'sh8000, 16'sh8000, 16'sh7fff},
             '{16'sh7fff, 16'sh8000, 16'sh8000}};
    send_matrix(mx);                                     // raw 16-bit extremes
    mx.m = '{'{16'sh8000, 16'sh7fff, 16'sh8000}, '{16'sh7fff, 16'sh7fff, 16'sh8000},
             '{16'sh8000, 16'sh7fff, 16'sh7fff}};
    send_matrix(mx);
    mx = diag_matrix(1, -16384, -16384);                 // x largest, r01 = r10 = 16384
    mx.m[0][1] = elem_t'(16384); mx.m[1][0] = elem_t'(16384);
    send_matrix(mx);

    // random: mostly rotations, some diagonal mixes and raw noise
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n > N_RANDOM - 150) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1:    send_matrix(noise_matrix());
        2, 3:    send_matrix(diag_matrix($urandom_range(0, 32768) - 16384,
                                         $urandom_range(0, 32768) - 16384,
                                         $urandom_range(0, 32768) - 16384));
        default: send_matrix(rot_matrix());
      endcase
    end
    in_ch.valid <= 1'b0;
    send_done = 1'b1;
  end

  // result side ready with random stall bursts
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result capture at the rising edge
  always @(posedge clk_i) begin
    quat_res_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.q  = '{out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w};
      got.br = out_ch.branch_taken;
      got.bad = out_ch.invalid;
      sb.check_quat(got);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_cnt >= WDOG_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (send_done && sb.pending.size() == 0) begin
        repeat (LATENCY + 5) @(posedge clk_i);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
          $display("Testbench completed without errors");
        end else begin
          $display("Testbench completed WITH ERRORS");
        end
        $finish;
      end
    end
  end

endmodule

// ----- rotation_matrix_to_quaternion_core.f -----
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion_core.sv
verif/tb_rotation_matrix_to_quaternion_core.sv
